[sv/stc_pkg.sv]
// -----------------------------------------------------------------------------
// stc_pkg
// Shared constants for the sphere time-to-contact unit: default sizes, the
// result status codes and the depth of the front-to-back queue.
// -----------------------------------------------------------------------------
package stc_pkg;

   localparam int DIMENSIONS_DEF    = 3;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int VALUE_WIDTH_DEF   = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] STATUS_FOUND   = 2'd0;
   localparam logic [1:0] STATUS_OVERLAP = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;

endpackage

[sv/stc_queue.sv]
// -----------------------------------------------------------------------------
// stc_queue
// Short FIFO between the front end and the solver engine.
// -----------------------------------------------------------------------------
module stc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int DEPTH = stc_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

[sv/stc_front.sv]
// -----------------------------------------------------------------------------
// stc_front
// Input side: holds the first sphere and turns each second sphere into a
// packed job (position and velocity differences, radius sum) for the queue.
// -----------------------------------------------------------------------------
module stc_front #(
   parameter int DIMENSIONS  = stc_pkg::DIMENSIONS_DEF,
   parameter int VALUE_WIDTH = stc_pkg::VALUE_WIDTH_DEF,
   localparam int DW = VALUE_WIDTH + 1,
   localparam int EW = 2 * DIMENSIONS * DW + VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_second_body,
   input  logic [VALUE_WIDTH-1:0] req_pos_x,
   input  logic [VALUE_WIDTH-1:0] req_pos_y,
   input  logic [VALUE_WIDTH-1:0] req_pos_z,
   input  logic [VALUE_WIDTH-1:0] req_vel_x,
   input  logic [VALUE_WIDTH-1:0] req_vel_y,
   input  logic [VALUE_WIDTH-1:0] req_vel_z,
   input  logic [VALUE_WIDTH-2:0] req_body_radius,
   output logic                   job_push,
   output logic [EW-1:0]          job_data,
   input  logic                   job_full
);

   localparam int V = VALUE_WIDTH;

   logic [V-1:0] pos_req [3];
   logic [V-1:0] vel_req [3];
   logic [V-1:0] held_pos_ff [DIMENSIONS];
   logic [V-1:0] held_vel_ff [DIMENSIONS];
   logic [V-2:0] held_radius_ff;
   logic         transfer;
   logic         load;

   assign pos_req[0] = req_pos_x;
   assign pos_req[1] = req_pos_y;
   assign pos_req[2] = req_pos_z;
   assign vel_req[0] = req_vel_x;
   assign vel_req[1] = req_vel_y;
   assign vel_req[2] = req_vel_z;

   assign req_stall = job_full;
   assign transfer  = req_valid && !req_stall;
   assign load      = transfer && !req_second_body;
   assign job_push  = transfer && req_second_body;

   // differences are held - new, one bit wider than the operands
   always_comb begin
      job_data = '0;
      for (int i = 0; i < DIMENSIONS; i++) begin
         job_data[i*DW +: DW] = {held_pos_ff[i][V-1], held_pos_ff[i]}
                               - {pos_req[i][V-1], pos_req[i]};
         job_data[DIMENSIONS*DW + i*DW +: DW] = {held_vel_ff[i][V-1], held_vel_ff[i]}
                                               - {vel_req[i][V-1], vel_req[i]};
      end
      job_data[2*DIMENSIONS*DW +: V] = {1'b0, held_radius_ff} + {1'b0, req_body_radius};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIMENSIONS; i++) begin
            held_pos_ff[i] <= '0;
            held_vel_ff[i] <= '0;
         end
         held_radius_ff <= '0;
      end else if (load) begin
         for (int i = 0; i < DIMENSIONS; i++) begin
            held_pos_ff[i] <= pos_req[i];
            held_vel_ff[i] <= vel_req[i];
         end
         held_radius_ff <= req_body_radius;
      end
   end

endmodule

[sv/stc_serial_mul.sv]
// -----------------------------------------------------------------------------
// stc_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle. Finishes as
// soon as the remaining multiplier bits are all zero.
// -----------------------------------------------------------------------------
module stc_serial_mul #(
   parameter int WIDTH = 8
) (
   input  logic               clock,
   input  logic               start,
   input  logic [WIDTH-1:0]   mcand,
   input  logic [WIDTH-1:0]   mplier,
   output logic               done,
   output logic [2*WIDTH-1:0] product
);

   logic [2*WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0]   mplier_ff, mplier_in;
   logic [2*WIDTH-1:0] acc_ff, acc_in;

   assign done    = (mplier_ff == '0);
   assign product = acc_ff;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         mcand_in  = {{WIDTH{1'b0}}, mcand};
         mplier_in = mplier;
         acc_in    = '0;
      end else if (!done) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[2*WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

endmodule

[sv/stc_engine.sv]
// -----------------------------------------------------------------------------
// stc_engine
// Back end: dot products, classification, bit-serial square root and
// restoring division, saturation, and the result output register.
// -----------------------------------------------------------------------------
module stc_engine #(
   parameter int DIMENSIONS    = stc_pkg::DIMENSIONS_DEF,
   parameter int FRACTION_BITS = stc_pkg::FRACTION_BITS_DEF,
   parameter int VALUE_WIDTH   = stc_pkg::VALUE_WIDTH_DEF,
   localparam int DW = VALUE_WIDTH + 1,
   localparam int EW = 2 * DIMENSIONS * DW + VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  logic [EW-1:0]          job_data,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_contact_time,
   output logic [1:0]             rsp_status,
   output logic                   rsp_saturated
);

   localparam int D   = DIMENSIONS;
   localparam int F   = FRACTION_BITS;
   localparam int V   = VALUE_WIDTH;
   localparam int SW  = 2 * DW + 2;          // sums of squares
   localparam int HW  = 2 * SW;              // h^2 and a*c
   localparam int QW  = HW + 2 * F;          // radicand
   localparam int RW  = SW + F;              // root, numerator, quotient
   localparam int CW  = $clog2(RW + 1);
   localparam int AXW = (D > 1) ? $clog2(D) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_AXIS, S_AXIS_WAIT, S_RS, S_RS_WAIT, S_CLASSIFY, S_SQ, S_SQ_WAIT,
      S_SQRT, S_NUM, S_DIV, S_SAT, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [AXW-1:0] axis_ff, axis_in;
   logic [DW-1:0] dp_ff [D];
   logic [DW-1:0] dp_in [D];
   logic [DW-1:0] dv_ff [D];
   logic [DW-1:0] dv_in [D];
   logic [V-1:0]  rs_ff, rs_in;
   logic [SW-1:0] dist_ff, dist_in;
   logic [SW-1:0] avel_ff, avel_in;
   logic [SW-1:0] hp_ff, hp_in;
   logic [SW-1:0] hn_ff, hn_in;
   logic [SW-1:0] rs2_ff, rs2_in;
   logic [SW-1:0] c_ff, c_in;
   logic [SW-1:0] habs_ff, habs_in;
   logic          hneg_ff, hneg_in;
   logic [QW-1:0] qs_ff, qs_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [SW-1:0] drem_ff, drem_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [V-1:0]  res_time_ff, res_time_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          res_sat_ff, res_sat_in;
   logic          out_valid_ff, out_valid_in;
   logic [V-1:0]  out_time_ff, out_time_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic          out_sat_ff, out_sat_in;

   logic          mul_start;
   logic [SW-1:0] mul_a [3];
   logic [SW-1:0] mul_b [3];
   logic [2:0]    mul_done;
   logic [HW-1:0] mul_p [3];

   logic [DW-1:0] dsel, vsel, mp, mv;
   logic [RW+3:0] sq_sh, sq_trial, sq_diff;
   logic          sq_ge;
   logic [SW:0]   dv_sh, dv_diff;
   logic          dv_ge;
   logic [V-1:0]  limit, t_mag;
   logic          sat;

   for (genvar g = 0; g < 3; g++) begin : g_mul
      stc_serial_mul #(.WIDTH(SW)) u_mul (
         .clock   (clock),
         .start   (mul_start),
         .mcand   (mul_a[g]),
         .mplier  (mul_b[g]),
         .done    (mul_done[g]),
         .product (mul_p[g])
      );
   end

   assign dsel = dp_ff[axis_ff];
   assign vsel = dv_ff[axis_ff];
   assign mp   = dsel[DW-1] ? (~dsel + 1'b1) : dsel;
   assign mv   = vsel[DW-1] ? (~vsel + 1'b1) : vsel;

   // one root digit per cycle
   assign sq_sh    = {rem_ff, qs_ff[QW-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_sh >= sq_trial);
   assign sq_diff  = sq_sh - sq_trial;

   // one quotient bit per cycle; the dividend register fills with quotient bits
   assign dv_sh   = {drem_ff, quo_ff[RW-1]};
   assign dv_ge   = (dv_sh >= {1'b0, avel_ff});
   assign dv_diff = dv_sh - {1'b0, avel_ff};

   // both roots share the sign of -h
   assign limit = hneg_ff ? {1'b0, {(V-1){1'b1}}} : {1'b1, {(V-1){1'b0}}};
   assign sat   = (quo_ff > RW'(limit));
   assign t_mag = sat ? limit : quo_ff[V-1:0];

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      dp_in         = dp_ff;
      dv_in         = dv_ff;
      rs_in         = rs_ff;
      dist_in       = dist_ff;
      avel_in       = avel_ff;
      hp_in         = hp_ff;
      hn_in         = hn_ff;
      rs2_in        = rs2_ff;
      c_in          = c_ff;
      habs_in       = habs_ff;
      hneg_in       = hneg_ff;
      qs_in         = qs_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      drem_in       = drem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_time_in   = res_time_ff;
      res_status_in = res_status_ff;
      res_sat_in    = res_sat_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_time_in   = out_time_ff;
      out_status_in = out_status_ff;
      out_sat_in    = out_sat_ff;
      job_pop       = 1'b0;
      mul_start     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mul_a[i] = '0;
         mul_b[i] = '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               for (int i = 0; i < D; i++) begin
                  dp_in[i] = job_data[i*DW +: DW];
                  dv_in[i] = job_data[D*DW + i*DW +: DW];
               end
               rs_in    = job_data[2*D*DW +: V];
               dist_in  = '0;
               avel_in  = '0;
               hp_in    = '0;
               hn_in    = '0;
               axis_in  = '0;
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            mul_start = 1'b1;
            mul_a[0]  = SW'(mp);
            mul_b[0]  = SW'(mp);
            mul_a[1]  = SW'(mv);
            mul_b[1]  = SW'(mv);
            mul_a[2]  = SW'(mp);
            mul_b[2]  = SW'(mv);
            state_in  = S_AXIS_WAIT;
         end
         S_AXIS_WAIT: begin
            if (&mul_done) begin
               dist_in = dist_ff + mul_p[0][SW-1:0];
               avel_in = avel_ff + mul_p[1][SW-1:0];
               if (dsel[DW-1] ^ vsel[DW-1]) begin
                  hn_in = hn_ff + mul_p[2][SW-1:0];
               end else begin
                  hp_in = hp_ff + mul_p[2][SW-1:0];
               end
               if (axis_ff == AXW'(D - 1)) begin
                  state_in = S_RS;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_AXIS;
               end
            end
         end
         S_RS: begin
            mul_start = 1'b1;
            mul_a[2]  = SW'(rs_ff);
            mul_b[2]  = SW'(rs_ff);
            state_in  = S_RS_WAIT;
         end
         S_RS_WAIT: begin
            if (&mul_done) begin
               rs2_in   = mul_p[2][SW-1:0];
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            c_in = dist_ff - rs2_ff;
            if (hp_ff >= hn_ff) begin
               habs_in = hp_ff - hn_ff;
               hneg_in = 1'b0;
            end else begin
               habs_in = hn_ff - hp_ff;
               hneg_in = 1'b1;
            end
            if (dist_ff <= rs2_ff) begin
               res_time_in   = '0;
               res_status_in = stc_pkg::STATUS_OVERLAP;
               res_sat_in    = 1'b0;
               state_in      = S_OUT;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            mul_start = 1'b1;
            mul_a[0]  = habs_ff;
            mul_b[0]  = habs_ff;
            mul_a[1]  = avel_ff;
            mul_b[1]  = c_ff;
            state_in  = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (&mul_done) begin
               if (avel_ff == '0 || mul_p[0] < mul_p[1]) begin
                  res_time_in   = {1'b1, {(V-1){1'b0}}};
                  res_status_in = stc_pkg::STATUS_NONE;
                  res_sat_in    = 1'b0;
                  state_in      = S_OUT;
               end else begin
                  qs_in    = {mul_p[0] - mul_p[1], {(2*F){1'b0}}};
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = CW'(RW);
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            qs_in   = {qs_ff[QW-3:0], 2'b00};
            root_in = {root_ff[RW-2:0], sq_ge};
            rem_in  = sq_ge ? sq_diff[RW+1:0] : sq_sh[RW+1:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            quo_in   = {habs_ff, {F{1'b0}}} - root_ff;
            drem_in  = '0;
            cnt_in   = CW'(RW);
            state_in = S_DIV;
         end
         S_DIV: begin
            quo_in  = {quo_ff[RW-2:0], dv_ge};
            drem_in = dv_ge ? dv_diff[SW-1:0] : dv_sh[SW-1:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            res_time_in   = hneg_ff ? t_mag : (~t_mag + 1'b1);
            res_status_in = stc_pkg::STATUS_FOUND;
            res_sat_in    = sat;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_time_in   = res_time_ff;
               out_status_in = res_status_ff;
               out_sat_in    = res_sat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
      end
      axis_ff       <= axis_in;
      dp_ff         <= dp_in;
      dv_ff         <= dv_in;
      rs_ff         <= rs_in;
      dist_ff       <= dist_in;
      avel_ff       <= avel_in;
      hp_ff         <= hp_in;
      hn_ff         <= hn_in;
      rs2_ff        <= rs2_in;
      c_ff          <= c_in;
      habs_ff       <= habs_in;
      hneg_ff       <= hneg_in;
      qs_ff         <= qs_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      drem_ff       <= drem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_time_ff   <= res_time_in;
      res_status_ff <= res_status_in;
      res_sat_ff    <= res_sat_in;
      out_time_ff   <= out_time_in;
      out_status_ff <= out_status_in;
      out_sat_ff    <= out_sat_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_contact_time = out_time_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_saturated    = out_sat_ff;

   a_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == stc_pkg::STATUS_OVERLAP
         |-> out_time_ff == '0 && !out_sat_ff)
      else $error("overlap result with nonzero time or saturation");

   a_none_min: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == stc_pkg::STATUS_NONE
         |-> out_time_ff == {1'b1, {(V-1){1'b0}}} && !out_sat_ff)
      else $error("no-contact result without most negative time");

   a_sat_found: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_sat_ff |-> out_status_ff == stc_pkg::STATUS_FOUND)
      else $error("saturation flagged on a result without a root");

   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQRT || state_ff == S_DIV |-> cnt_ff != '0)
      else $error("iteration counter ran out inside sqrt or divide");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == S_AXIS)
      else $error("job taken without starting the dot products");

endmodule

[sv/sphere_time_to_contact_unit.sv]
// The serial multipliers stop early on small operands. The back end solves one
// item at a time; its serial multipliers, the one-digit-per-cycle square root and
// the one-bit-per-cycle divider set its pace.
// Up to two items queue behind the one being solved; load items go into the held
// sphere and do not enter the queue.
// Reset: synchronous; clears the held sphere to zero, empties the queue and output.
// -----------------------------------------------------------------------------
// sphere_time_to_contact_unit
// Time of first contact between a held sphere and each following sphere.
// -----------------------------------------------------------------------------
module sphere_time_to_contact_unit #(
   parameter int DIMENSIONS    = stc_pkg::DIMENSIONS_DEF,
   parameter int FRACTION_BITS = stc_pkg::FRACTION_BITS_DEF,
   parameter int VALUE_WIDTH   = stc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_second_body,
   input  logic signed [VALUE_WIDTH-1:0] req_pos_x,
   input  logic signed [VALUE_WIDTH-1:0] req_pos_y,
   input  logic signed [VALUE_WIDTH-1:0] req_pos_z,
   input  logic signed [VALUE_WIDTH-1:0] req_vel_x,
   input  logic signed [VALUE_WIDTH-1:0] req_vel_y,
   input  logic signed [VALUE_WIDTH-1:0] req_vel_z,
   input  logic        [VALUE_WIDTH-2:0] req_body_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_contact_time,
   output logic        [1:0]             rsp_status,
   output logic                          rsp_saturated
);

   localparam int DW = VALUE_WIDTH + 1;
   localparam int EW = 2 * DIMENSIONS * DW + VALUE_WIDTH;

   logic          push;
   logic [EW-1:0] push_data;
   logic          full;
   logic          pop;
   logic          head_valid;
   logic [EW-1:0] head_data;

   stc_front #(
      .DIMENSIONS  (DIMENSIONS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_second_body (req_second_body),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_vel_z       (req_vel_z),
      .req_body_radius (req_body_radius),
      .job_push        (push),
      .job_data        (push_data),
      .job_full        (full)
   );

   stc_queue #(.WIDTH(EW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   stc_engine #(
      .DIMENSIONS    (DIMENSIONS),
      .FRACTION_BITS (FRACTION_BITS),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (head_valid),
      .job_data         (head_data),
      .job_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_contact_time (rsp_contact_time),
      .rsp_status       (rsp_status),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
